// File: sv/topk_accuracy_counter_core_assert.svh
// assertion macros for the checker of the top-k accuracy counter
// no dependencies; take in with an include of the bare file name
`ifndef TOPK_ACCURACY_COUNTER_CORE_ASSERT_SVH
`define TOPK_ACCURACY_COUNTER_CORE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define TKAC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tkac assertion violated");

// consequent checked in the cycle after the antecedent
`define TKAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tkac assertion violated");

`endif

// File: sv/tkac_pkg.sv
// shared types and constants of the top-k accuracy counter
// no dependencies; used by every module of the block but tkac_ram
package tkac_pkg;

	localparam int unsigned TKAC_MAX_CLASSES = 1024;
	localparam int unsigned TKAC_SCORE_W     = 16;
	localparam int unsigned TKAC_LABEL_W     = 10;
	localparam int unsigned TKAC_TOPK_W      = 11;
	localparam int unsigned TKAC_TOTAL_W     = 32;
	localparam int unsigned TKAC_ADDR_W      = 4;
	localparam int unsigned TKAC_DATA_W      = 32;

	// register index codes, taken from paddr[3:2]
	typedef enum logic [1:0] {
		REG_TOP_K        = 2'd0,
		REG_IGNORE_EN    = 2'd1,
		REG_IGNORE_LABEL = 2'd2
	} tkac_reg_t;

	// one input word: a class score of the current sample
	typedef struct packed {
		logic signed [TKAC_SCORE_W-1:0] score;
		logic [TKAC_LABEL_W-1:0]        true_label;
		logic                           last_score;
	} tkac_item_t;

	// one result word per sample
	typedef struct packed {
		logic                    sample_hit;
		logic                    sample_ignored;
		logic                    label_error;
		logic [TKAC_TOTAL_W-1:0] hit_total;
		logic [TKAC_TOTAL_W-1:0] sample_total;
	} tkac_res_t;

	// configuration register contents
	typedef struct packed {
		logic [TKAC_TOPK_W-1:0]  top_k;
		logic                    ignore_enable;
		logic [TKAC_LABEL_W-1:0] ignore_label;
	} tkac_cfg_t;

	localparam tkac_cfg_t TKAC_CFG_RESET = '{
		top_k:         TKAC_TOPK_W'(1),
		ignore_enable: 1'b0,
		ignore_label:  '0
	};

endpackage

// File: sv/tkac_ram.sv
// generic single-port-write, single-port-read RAM with registered read data
// no dependencies; holds the score buffer of the accuracy counter
module tkac_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: sv/tkac_cfg.sv
// APB-style configuration registers of the top-k accuracy counter
// depends on tkac_pkg (register codes, config struct, reset values)
module tkac_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [tkac_pkg::TKAC_ADDR_W-1:0] paddr,
	input  logic [tkac_pkg::TKAC_DATA_W-1:0] pwdata,
	output logic [tkac_pkg::TKAC_DATA_W-1:0] prdata,
	output logic                             pready,
	output tkac_pkg::tkac_cfg_t              cfg
);

	import tkac_pkg::*;

	tkac_cfg_t  cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[3:2];

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= TKAC_CFG_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_TOP_K:        cfg_q.top_k         <= pwdata[TKAC_TOPK_W-1:0];
				REG_IGNORE_EN:    cfg_q.ignore_enable <= pwdata[0];
				REG_IGNORE_LABEL: cfg_q.ignore_label  <= pwdata[TKAC_LABEL_W-1:0];
				default:          cfg_q               <= cfg_q;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (reg_idx)
			REG_TOP_K:        prdata = TKAC_DATA_W'(cfg_q.top_k);
			REG_IGNORE_EN:    prdata = TKAC_DATA_W'(cfg_q.ignore_enable);
			REG_IGNORE_LABEL: prdata = TKAC_DATA_W'(cfg_q.ignore_label);
			default:          prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// File: sv/tkac_rank.sv
// rank walker: reads the buffered scores one per cycle and counts classes
// ranking above the true label; depends on tkac_pkg (widths)
module tkac_rank #(
	parameter int unsigned MAX_CLASSES = tkac_pkg::TKAC_MAX_CLASSES,
	localparam int unsigned AW         = $clog2(MAX_CLASSES),
	localparam int unsigned CNT_W      = $clog2(MAX_CLASSES + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [tkac_pkg::TKAC_LABEL_W-1:0] label,
	input  logic [CNT_W-1:0]                  n,
	output logic                              ren,
	output logic [AW-1:0]                     raddr,
	input  logic [tkac_pkg::TKAC_SCORE_W-1:0] rdata,
	output logic                              done,
	output logic [CNT_W-1:0]                  above
);

	import tkac_pkg::*;

	typedef enum logic [1:0] {
		R_IDLE,
		R_REF,
		R_WALK
	} rank_state_t;

	rank_state_t                    state_q;
	logic [CNT_W-1:0]               idx_cnt_q;
	logic                           ref_pend_q;
	logic                           rd_pend_q;
	logic                           done_q;
	logic [CNT_W-1:0]               above_q;
	logic signed [TKAC_SCORE_W-1:0] ref_q;
	logic [AW-1:0]                  rd_idx_q;
	logic                           issue;
	logic signed [TKAC_SCORE_W-1:0] cur_score;
	logic                           ranks_above;

	// read issue: the label's score first, then every class in order
	assign issue = (state_q == R_WALK) && (idx_cnt_q < n);
	assign ren   = (state_q == R_REF) || issue;
	assign raddr = (state_q == R_REF) ? AW'(label) : AW'(idx_cnt_q);

	// the compare: higher score, or equal score at a larger index
	assign cur_score   = $signed(rdata);
	assign ranks_above = (cur_score > ref_q) ||
		((cur_score == ref_q) && (rd_idx_q > AW'(label)));

	// sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= R_IDLE;
			idx_cnt_q  <= '0;
			ref_pend_q <= 1'b0;
			rd_pend_q  <= 1'b0;
			done_q     <= 1'b0;
			above_q    <= '0;
		end else begin
			done_q <= (state_q == R_WALK) && !issue && !rd_pend_q && !ref_pend_q;
			unique case (state_q)
				R_IDLE: begin
					if (start) begin
						state_q   <= R_REF;
						idx_cnt_q <= '0;
						above_q   <= '0;
						rd_pend_q <= 1'b0;
					end
				end
				R_REF: begin
					state_q    <= R_WALK;
					ref_pend_q <= 1'b1;
				end
				R_WALK: begin
					ref_pend_q <= 1'b0;
					rd_pend_q  <= issue;
					if (issue) begin
						idx_cnt_q <= idx_cnt_q + CNT_W'(1);
					end
					if (rd_pend_q && ranks_above) begin
						above_q <= above_q + CNT_W'(1);
					end
					if (!issue && !rd_pend_q && !ref_pend_q) begin
						state_q <= R_IDLE;
					end
				end
				default: state_q <= R_IDLE;
			endcase
		end
	end

	// reference score and index of the word in flight
	always_ff @(posedge clk) begin
		if (ref_pend_q) begin
			ref_q <= cur_score;
		end
		if (issue) begin
			rd_idx_q <= raddr;
		end
	end

	assign done  = done_q;
	assign above = above_q;

endmodule

// File: sv/topk_accuracy_counter_core.sv
// top level of the top-k accuracy counter: score buffer, sample control, totals
// depends on tkac_pkg, tkac_ram, tkac_cfg, tkac_rank
//
//  channel   handshake                 word type     direction
//  item      item_valid / item_stall   tkac_item_t   in
//  res       res_valid / res_stall     tkac_res_t    out
//  config    psel / penable / pready   32-bit APB    in, read back
//
// a sample of n scores loads one score per cycle into the buffer while item_stall is low
// the last score starts a walk over the buffer on its single read port;
// item_stall stays high until the result is loaded into res
// ignored or mislabeled samples skip the walk and go straight to the result state
// arst_n clears control, totals and config; the buffer needs no clearing
// a waiting result is held in res while further scores of the next sample load
module topk_accuracy_counter_core #(
	parameter int unsigned MAX_CLASSES = tkac_pkg::TKAC_MAX_CLASSES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  tkac_pkg::tkac_item_t             item,
	output logic                             res_valid,
	input  logic                             res_stall,
	output tkac_pkg::tkac_res_t              res,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [tkac_pkg::TKAC_ADDR_W-1:0] paddr,
	input  logic [tkac_pkg::TKAC_DATA_W-1:0] pwdata,
	output logic [tkac_pkg::TKAC_DATA_W-1:0] prdata,
	output logic                             pready
);

	import tkac_pkg::*;

	localparam int unsigned AW     = $clog2(MAX_CLASSES);
	localparam int unsigned CNT_W  = $clog2(MAX_CLASSES + 1);
	localparam int unsigned LCMP_W = (CNT_W > TKAC_LABEL_W) ? CNT_W : TKAC_LABEL_W;
	localparam int unsigned KCMP_W = (CNT_W > TKAC_TOPK_W) ? CNT_W : TKAC_TOPK_W;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_RANK,
		ST_RESULT
	} core_state_t;

	core_state_t             state_q;
	logic [CNT_W-1:0]        pos_q;
	logic [CNT_W-1:0]        n_q;
	logic [TKAC_LABEL_W-1:0] label_q;
	logic                    ignored_q;
	logic                    err_q;
	logic                    start_q;
	logic                    res_valid_q;
	tkac_res_t               res_q;
	logic [TKAC_TOTAL_W-1:0] hit_tot_q;
	logic [TKAC_TOTAL_W-1:0] samp_tot_q;

	tkac_cfg_t               cfg;
	logic                    accept;
	logic                    room;
	logic [CNT_W-1:0]        n_next;
	logic                    ignore_now;
	logic                    label_bad;
	logic                    start_now;
	logic                    rank_ren;
	logic [AW-1:0]           rank_raddr;
	logic [TKAC_SCORE_W-1:0] rank_rdata;
	logic                    rank_done;
	logic [CNT_W-1:0]        rank_above;
	logic                    hit_now;
	logic                    counted;
	logic                    res_free;
	logic                    res_load;

	// configuration registers
	tkac_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input side: one score per cycle while loading
	assign item_stall = (state_q != ST_LOAD);
	assign accept     = item_valid && !item_stall;
	assign room       = (pos_q < CNT_W'(MAX_CLASSES));
	assign n_next     = room ? (pos_q + CNT_W'(1)) : pos_q;
	assign ignore_now = cfg.ignore_enable && (item.true_label == cfg.ignore_label);
	assign label_bad  = (LCMP_W'(item.true_label) >= LCMP_W'(n_next));
	assign start_now  = accept && item.last_score && !ignore_now && !label_bad;

	// score buffer
	tkac_ram #(
		.WIDTH (TKAC_SCORE_W),
		.DEPTH (MAX_CLASSES)
	) u_buf (
		.clk   (clk),
		.we    (accept && room),
		.waddr (AW'(pos_q)),
		.wdata (item.score),
		.re    (rank_ren),
		.raddr (rank_raddr),
		.rdata (rank_rdata)
	);

	// rank walker
	tkac_rank #(
		.MAX_CLASSES (MAX_CLASSES)
	) u_rank (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.label  (label_q),
		.n      (n_q),
		.ren    (rank_ren),
		.raddr  (rank_raddr),
		.rdata  (rank_rdata),
		.done   (rank_done),
		.above  (rank_above)
	);

	// outcome of the finished sample
	assign counted  = !ignored_q && !err_q;
	assign hit_now  = counted && (KCMP_W'(rank_above) < KCMP_W'(cfg.top_k));
	assign res_free = !res_valid_q || !res_stall;
	assign res_load = (state_q == ST_RESULT) && res_free;

	// sample sequencer, totals and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			pos_q       <= '0;
			n_q         <= '0;
			label_q     <= '0;
			ignored_q   <= 1'b0;
			err_q       <= 1'b0;
			start_q     <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
			hit_tot_q   <= '0;
			samp_tot_q  <= '0;
		end else begin
			start_q <= start_now;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (item.last_score) begin
							pos_q     <= '0;
							n_q       <= n_next;
							label_q   <= item.true_label;
							ignored_q <= ignore_now;
							err_q     <= !ignore_now && label_bad;
							if (ignore_now || label_bad) begin
								state_q <= ST_RESULT;
							end else begin
								state_q <= ST_RANK;
							end
						end else begin
							pos_q <= n_next;
						end
					end
				end
				ST_RANK: begin
					if (rank_done) begin
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (res_free) begin
						res_q.sample_hit     <= hit_now;
						res_q.sample_ignored <= ignored_q;
						res_q.label_error    <= err_q;
						res_q.hit_total      <= (hit_now && (hit_tot_q != '1)) ?
							hit_tot_q + TKAC_TOTAL_W'(1) : hit_tot_q;
						res_q.sample_total   <= (counted && (samp_tot_q != '1)) ?
							samp_tot_q + TKAC_TOTAL_W'(1) : samp_tot_q;
						if (hit_now && (hit_tot_q != '1)) begin
							hit_tot_q <= hit_tot_q + TKAC_TOTAL_W'(1);
						end
						if (counted && (samp_tot_q != '1)) begin
							samp_tot_q <= samp_tot_q + TKAC_TOTAL_W'(1);
						end
						state_q <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// File: sv/tkac_checker.sv
// port-level checker of the top-k accuracy counter, bound to the top level
// depends on tkac_pkg and topk_accuracy_counter_core_assert.svh
`include "topk_accuracy_counter_core_assert.svh"

module tkac_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 item_valid,
	input logic                 item_stall,
	input tkac_pkg::tkac_item_t item,
	input logic                 res_valid,
	input logic                 res_stall,
	input tkac_pkg::tkac_res_t  res
);

	logic item_acc;
	logic outcome_ok;

	assign item_acc   = item_valid && !item_stall;
	assign outcome_ok = !(res.sample_hit && (res.sample_ignored || res.label_error)) &&
		!(res.sample_ignored && res.label_error);

	// a stalled result word stays put
	`TKAC_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable(res))

	// the last score of a sample makes the block busy
	`TKAC_ASSERT_NEXT(a_busy_after_last, clk, arst_n, item_acc && item.last_score, item_stall)

	// a new result only appears out of a busy phase
	`TKAC_ASSERT_SAME(a_res_from_busy, clk, arst_n, $rose(res_valid), $past(item_stall))

	// hit, ignore and label error are mutually exclusive
	`TKAC_ASSERT_SAME(a_outcome_excl, clk, arst_n, res_valid, outcome_ok)

endmodule

bind topk_accuracy_counter_core tkac_checker u_tkac_checker (.*);
